/* hdl/avb_pkg.sv */
// Shared types and constants for the AVCC to Annex B converter.
package avb_pkg;

  // Default widths and depths
  localparam int unsigned LEN_BITS_DEF    = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Length prefix sizes that are supported
  localparam logic [2:0] LEN_SIZE_1   = 3'd1;
  localparam logic [2:0] LEN_SIZE_2   = 3'd2;
  localparam logic [2:0] LEN_SIZE_4   = 3'd4;
  localparam logic [2:0] LEN_SIZE_RST = LEN_SIZE_4;

  // Start code bytes
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // Work item handed from the front end to the back end
  typedef struct packed {
    logic [7:0] data_byte;  // payload byte, used when has_byte is set
    logic       has_byte;   // pass one payload byte
    logic       has_code;   // emit the four start code bytes
    logic       has_err;    // emit one error beat at the end
  } cmd_t;

  // Output beat being presented by the back end
  typedef enum logic [2:0] {
    PH_BYTE,
    PH_SC0,
    PH_SC1,
    PH_SC2,
    PH_SC3,
    PH_ERR
  } phase_e;

endpackage

/* hdl/avb_in_if.sv */
// Input byte channel: valid/ready handshake with one sample byte per beat.
interface avb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sample_last;

  modport source (output valid, data_byte, sample_last, input ready);
  modport sink   (input valid, data_byte, sample_last, output ready);
endinterface

/* hdl/avb_out_if.sv */
// Output byte channel: valid/ready handshake with one Annex B result per beat.
interface avb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_error;
  logic       code_first;
  logic       run_last;

  modport source (output valid, out_byte, is_error, code_first, run_last, input ready);
  modport sink   (input valid, out_byte, is_error, code_first, run_last, output ready);
endinterface

/* hdl/avcc_to_annexb_converter.sv */
// AVCC to Annex B converter: one byte per cycle unless it is stalled, start codes take 4 output beats.
// The first result beat of an input beat passes through the command queue and then the current command register.
// Throughput: one input beat per cycle for payload; the last prefix byte yields
// 4 or 5 output beats, so input stalls once the command queue fills.
// The back end drives at most one output beat per cycle.
// Reset: asynchronous active low; clears parser, queue and output, length_size = 4.
module avcc_to_annexb_converter #(
  parameter int unsigned LEN_BITS    = avb_pkg::LEN_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = avb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  avb_in_if.sink     byte_in_i,
  avb_out_if.source  byte_out_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i
);
  import avb_pkg::*;

  logic [2:0] length_size_q;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  cmd_t       front_cmd;
  cmd_t       queue_cmd;

  // Length prefix size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_size_q <= LEN_SIZE_RST;
    end else if (cfg_we_i) begin
      length_size_q <= cfg_wdata_i;
    end
  end

  avb_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_s          (byte_in_i),
    .length_size_i (length_size_q),
    .full_i        (q_full),
    .push_o        (q_push),
    .cmd_o         (front_cmd)
  );

  avb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd)
  );

  avb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (queue_cmd),
    .q_pop_o   (q_pop),
    .out_s     (byte_out_o)
  );

endmodule

/* hdl/avb_front.sv */
// Front end: takes input beats, parses length prefixes and counts payload bytes.
module avb_front #(
  parameter int unsigned LEN_BITS = avb_pkg::LEN_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  avb_in_if.sink        in_s,
  input  logic [2:0]    length_size_i,
  input  logic          full_i,
  output logic          push_o,
  output avb_pkg::cmd_t cmd_o
);
  import avb_pkg::*;

  logic                in_payload_q, in_payload_d;
  logic [2:0]          prefix_count_q, prefix_count_d;
  logic [LEN_BITS-1:0] length_acc_q, length_acc_d;
  logic [LEN_BITS-1:0] bytes_left_q, bytes_left_d;

  logic                accept;
  logic                size_ok;
  logic [LEN_BITS+7:0] acc_wide;
  logic [LEN_BITS-1:0] acc_shift;
  logic [LEN_BITS-1:0] left_dec;
  logic [2:0]          cnt_inc;
  cmd_t                cmd;

  assign in_s.ready = !full_i;
  assign accept     = in_s.valid && !full_i;

  assign size_ok   = (length_size_i == LEN_SIZE_1) || (length_size_i == LEN_SIZE_2) ||
                     (length_size_i == LEN_SIZE_4);
  assign acc_wide  = {length_acc_q, in_s.data_byte};
  assign acc_shift = acc_wide[LEN_BITS-1:0];
  assign left_dec  = bytes_left_q - LEN_BITS'(1);
  assign cnt_inc   = prefix_count_q + 3'd1;

  // Parse state update and command build
  always_comb begin
    in_payload_d   = in_payload_q;
    prefix_count_d = prefix_count_q;
    length_acc_d   = length_acc_q;
    bytes_left_d   = bytes_left_q;
    cmd            = '0;
    cmd.data_byte  = in_s.data_byte;

    if (accept) begin
      if (in_payload_q) begin
        cmd.has_byte = 1'b1;
        bytes_left_d = left_dec;
        in_payload_d = (left_dec != '0);
        if (in_s.sample_last) begin
          cmd.has_err = (left_dec != '0);
        end
      end else if (!size_ok) begin
        cmd.has_err = in_s.sample_last;
      end else begin
        length_acc_d   = acc_shift;
        prefix_count_d = cnt_inc;
        if (cnt_inc >= length_size_i) begin
          cmd.has_code   = 1'b1;
          bytes_left_d   = acc_shift;
          in_payload_d   = (acc_shift != '0);
          prefix_count_d = '0;
          length_acc_d   = '0;
          if (in_s.sample_last) begin
            cmd.has_err = (acc_shift != '0);
          end
        end else begin
          cmd.has_err = in_s.sample_last;
        end
      end

      // Every sample boundary resynchronizes the parser
      if (in_s.sample_last) begin
        in_payload_d   = 1'b0;
        prefix_count_d = '0;
        length_acc_d   = '0;
        bytes_left_d   = '0;
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.has_byte || cmd.has_code || cmd.has_err);

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      prefix_count_q <= '0;
      length_acc_q   <= '0;
      bytes_left_q   <= '0;
    end else begin
      in_payload_q   <= in_payload_d;
      prefix_count_q <= prefix_count_d;
      length_acc_q   <= length_acc_d;
      bytes_left_q   <= bytes_left_d;
    end
  end

endmodule

/* hdl/avb_queue.sv */
// Small command FIFO between the front end and the back end.
module avb_queue #(
  parameter int unsigned DEPTH = avb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  avb_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output avb_pkg::cmd_t cmd_o
);
  import avb_pkg::*;

  // DEPTH must be a power of two so the pointers wrap on their own; the block itself does not enforce it
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam logic [AW:0] FULL_CNT = (AW+1)'(DEPTH);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hdl/avb_back.sv */
// Back end: expands each command into its output beats, one beat per cycle while the output is ready.
module avb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  avb_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  avb_out_if.source     out_s
);
  import avb_pkg::*;

  cmd_t   cur_q, cur_d;
  logic   cur_vld_q, cur_vld_d;
  phase_e phase_q, phase_d;

  phase_e first_ph;
  phase_e next_ph;
  logic   is_last;
  logic   beat_done;
  logic   load;

  // First beat of a freshly loaded command
  always_comb begin
    if (q_cmd_i.has_byte) begin
      first_ph = PH_BYTE;
    end else if (q_cmd_i.has_code) begin
      first_ph = PH_SC0;
    end else begin
      first_ph = PH_ERR;
    end
  end

  // Beat sequencing within the current command
  always_comb begin
    next_ph = PH_ERR;
    is_last = 1'b1;
    case (phase_q)
      PH_BYTE: begin
        is_last = !cur_q.has_err;
      end
      PH_SC0: begin
        next_ph = PH_SC1;
        is_last = 1'b0;
      end
      PH_SC1: begin
        next_ph = PH_SC2;
        is_last = 1'b0;
      end
      PH_SC2: begin
        next_ph = PH_SC3;
        is_last = 1'b0;
      end
      PH_SC3: begin
        is_last = !cur_q.has_err;
      end
      PH_ERR: begin
        is_last = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  assign beat_done = cur_vld_q && out_s.ready;
  assign load      = !cur_vld_q || (beat_done && is_last);
  assign q_pop_o   = load && q_valid_i;

  // Current command register
  always_comb begin
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    phase_d   = phase_q;
    if (load) begin
      cur_vld_d = q_valid_i;
      cur_d     = q_cmd_i;
      phase_d   = first_ph;
    end else if (beat_done) begin
      phase_d = next_ph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      phase_q   <= PH_BYTE;
    end else begin
      cur_vld_q <= cur_vld_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Output beat decode
  always_comb begin
    out_s.out_byte   = SC_ZERO;
    out_s.is_error   = 1'b0;
    out_s.code_first = 1'b0;
    case (phase_q)
      PH_BYTE: out_s.out_byte   = cur_q.data_byte;
      PH_SC0:  out_s.code_first = 1'b1;
      PH_SC1:  out_s.out_byte   = SC_ZERO;
      PH_SC2:  out_s.out_byte   = SC_ZERO;
      PH_SC3:  out_s.out_byte   = SC_ONE;
      PH_ERR:  out_s.is_error   = 1'b1;
      default: out_s.out_byte   = SC_ZERO;
    endcase
  end

  assign out_s.valid    = cur_vld_q;
  assign out_s.run_last = is_last;

endmodule

/* hdl/avb_chk.sv */
// Port-level checker for the converter, bound to the top level.
module avb_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_error,
  input logic       code_first,
  input logic       run_last
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_error) &&
                                $stable(code_first) && $stable(run_last))
    else $error("output beat changed while stalled");

  // Error beat is zero and closes its run
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_error |-> out_byte == 8'h00 && !code_first && run_last)
    else $error("malformed error beat");

  // Start code head is zero and never ends a run
  a_code_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && code_first |-> out_byte == 8'h00 && !is_error && !run_last)
    else $error("malformed start code head");

  // Rest of a start code follows without a bubble
  a_code_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && code_first |=> out_valid && !code_first && !is_error)
    else $error("start code interrupted");

endmodule

bind avcc_to_annexb_converter avb_chk u_avb_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (byte_out_o.valid),
  .out_ready  (byte_out_o.ready),
  .out_byte   (byte_out_o.out_byte),
  .is_error   (byte_out_o.is_error),
  .code_first (byte_out_o.code_first),
  .run_last   (byte_out_o.run_last)
);
